// ===== hdl/fwd53_pkg.sv =====
// shared types and constants for the forward 5/3 lifting wavelet
// no dependencies

package fwd53_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int IN_BITS         = 32;
    localparam int CFG_BITS        = 16;
    localparam int COEF_BITS       = 34;
    localparam int IDX_BITS        = 15;
    localparam int OUT_TDATA_BITS  = 56;
    localparam int QUEUE_DEPTH     = 4;
    localparam logic [CFG_BITS-1:0] ROW_LEN_RESET = 16'd8;

    // band of a coefficient
    localparam logic BAND_APPROX = 1'b0;
    localparam logic BAND_DETAIL = 1'b1;

    // how the back end turns one queued job into coefficients
    typedef struct packed {
        logic                pass;
        logic                mid;
        logic                first_a;
        logic                done_a;
        logic                tail;
        logic [IDX_BITS-1:0] ci;
    } t_job_ctl;

    typedef enum logic [1:0] {
        STEP_DETAIL,
        STEP_APPROX,
        STEP_TAIL
    } t_step;

endpackage

// ===== hdl/fwd53_front.sv =====
// front end: row position tracking, sample classification, job generation
// depends on fwd53_pkg

module fwd53_front
    import fwd53_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_BITS-1:0]           i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [IN_BITS-1:0]            i_sample,
    input  logic                          i_q_full,
    output logic                          o_push,
    output t_job_ctl                      o_ctl,
    output logic signed [SAMPLE_BITS-1:0] o_x,
    output logic signed [SAMPLE_BITS-1:0] o_e,
    output logic signed [SAMPLE_BITS-1:0] o_odd
);

    logic [LENGTH_BITS-1:0]        r_len;
    logic [LENGTH_BITS-1:0]        r_cnt;
    logic [IDX_BITS-1:0]           r_ci;
    logic signed [SAMPLE_BITS-1:0] r_e;
    logic signed [SAMPLE_BITS-1:0] r_odd;

    logic [LENGTH_BITS-1:0]        w_n;
    logic                          w_acc;
    logic                          w_one;
    logic                          w_first;
    logic                          w_odd;
    logic                          w_last;
    logic signed [SAMPLE_BITS-1:0] w_x;

    assign w_x     = i_sample[SAMPLE_BITS-1:0];
    assign w_n     = (r_len == '0) ? LENGTH_BITS'(1) : r_len;
    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && !i_q_full;
    assign w_one   = (w_n == LENGTH_BITS'(1));
    assign w_first = (r_cnt == '0);
    assign w_odd   = r_cnt[0];
    assign w_last  = ((LENGTH_BITS+1)'(r_cnt) + (LENGTH_BITS+1)'(1)) == (LENGTH_BITS+1)'(w_n);

    assign o_push = w_acc && (w_one || (!w_first && (!w_odd || w_last)));

    always_comb begin
        o_ctl.pass    = w_one;
        o_ctl.mid     = !w_odd;
        o_ctl.first_a = (r_cnt == LENGTH_BITS'(1)) || (r_cnt == LENGTH_BITS'(2));
        o_ctl.done_a  = w_odd;
        o_ctl.tail    = !w_odd && w_last;
        o_ctl.ci      = r_ci;
    end

    assign o_x   = w_x;
    assign o_e   = r_e;
    assign o_odd = r_odd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LENGTH_BITS'(ROW_LEN_RESET);
            r_cnt <= '0;
            r_ci  <= '0;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata[LENGTH_BITS-1:0];
            r_cnt <= '0;
            r_ci  <= '0;
        end else if (w_acc) begin
            if (w_one || (!w_first && w_last)) begin
                r_cnt <= '0;
                r_ci  <= '0;
            end else begin
                r_cnt <= r_cnt + LENGTH_BITS'(1);
                if (!w_first && !w_odd) begin
                    r_ci <= r_ci + IDX_BITS'(1);
                end
            end
        end
    end

    // sample history, always written before use within a row
    always_ff @(posedge i_clk) begin
        if (w_acc && !w_one) begin
            if (w_first || !w_odd) begin
                r_e <= w_x;
            end else if (!w_last) begin
                r_odd <= w_x;
            end
        end
    end

    a_cnt_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < w_n)
        else $error("row position beyond row length");

endmodule

// ===== hdl/fwd53_queue.sv =====
// small job queue between front and back end
// depends on fwd53_pkg

module fwd53_queue
    import fwd53_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> (r_rd == r_wr))
        else $error("queue pointers disagree with fill count");

endmodule

// ===== hdl/fwd53_back.sv =====
// back end: detail and approximation arithmetic, result sequencing, output register
// depends on fwd53_pkg

module fwd53_back
    import fwd53_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_pop,
    input  t_job_ctl                      i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_e,
    input  logic signed [SAMPLE_BITS-1:0] i_odd,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [COEF_BITS-1:0]          o_coef,
    output logic                          o_band,
    output logic [IDX_BITS-1:0]           o_idx,
    output logic                          o_last
);

    localparam int SB = SAMPLE_BITS;
    localparam int V  = SAMPLE_BITS + 2;

    // stage 1: neighbor sum
    logic                   r_s1_v;
    t_job_ctl               r_s1_ctl;
    logic signed [SB-1:0]   r_s1_x;
    logic signed [SB-1:0]   r_s1_e;
    logic signed [SB-1:0]   r_s1_odd;
    logic signed [SB:0]     r_s1_sum;
    // stage 2: detail
    logic                   r_s2_v;
    t_job_ctl               r_s2_ctl;
    logic signed [SB-1:0]   r_s2_x;
    logic signed [SB-1:0]   r_s2_e;
    logic signed [SB:0]     r_s2_d;
    logic signed [SB:0]     r_pd;
    // stage 3: result sequencing
    logic                   r_s3_v;
    t_job_ctl               r_s3_ctl;
    logic signed [SB:0]     r_s3_d;
    logic signed [V-1:0]    r_s3_a;
    logic signed [V-1:0]    r_s3_tl;
    t_step                  r_step;
    t_step                  n_step;
    // output register
    logic                   r_o_valid;
    logic signed [V-1:0]    r_o_coef;
    logic                   r_o_band;
    logic [IDX_BITS-1:0]    r_o_idx;
    logic                   r_o_last;

    logic                   w_s1_ready;
    logic                   w_s2_ready;
    logic                   w_s3_load;
    logic                   w_emit;
    t_step                  w_last_step;
    logic signed [SB:0]     w_sum;
    logic [SB:0]            w_sum_r;
    logic signed [SB-1:0]   w_h;
    logic signed [SB-1:0]   w_base;
    logic signed [SB:0]     w_d;
    logic [SB+1:0]          w_p1;
    logic [SB+1:0]          w_p1r;
    logic signed [SB:0]     w_t2;
    logic [SB+2:0]          w_p4;
    logic [SB+2:0]          w_p4r;
    logic signed [SB:0]     w_t4;
    logic signed [SB:0]     w_q;
    logic signed [V-1:0]    w_a;
    logic signed [V-1:0]    w_tl;
    logic signed [V-1:0]    w_res;
    logic                   w_band;
    logic [IDX_BITS-1:0]    w_idx;
    logic                   w_done;

    assign w_s1_ready = !r_s1_v || w_s2_ready;
    assign w_s2_ready = !r_s2_v || w_s3_load;
    assign o_pop      = i_q_valid && w_s1_ready;

    assign w_sum = i_ctl.mid ? ((SB+1)'(i_e) + (SB+1)'(i_x)) : ((SB+1)'(i_e) + (SB+1)'(i_e));

    // truncating halve of the neighbor sum
    assign w_sum_r = r_s1_sum + (SB+1)'(r_s1_sum[SB]);
    assign w_h     = w_sum_r[SB:1];
    assign w_base  = r_s1_ctl.mid ? r_s1_odd : r_s1_x;
    assign w_d     = (SB+1)'(w_base) - (SB+1)'(w_h);

    // truncating (1 + d) / 2 and (2 + pd + d) / 4
    assign w_p1  = (SB+2)'(r_s2_d) + (SB+2)'(1);
    assign w_p1r = w_p1 + (SB+2)'(w_p1[SB+1]);
    assign w_t2  = w_p1r[SB+1:1];
    assign w_p4  = (SB+3)'(r_pd) + (SB+3)'(r_s2_d) + (SB+3)'(2);
    assign w_p4r = w_p4 + (w_p4[SB+2] ? (SB+3)'(3) : (SB+3)'(0));
    assign w_t4  = w_p4r[SB+2:2];
    assign w_q   = r_s2_ctl.first_a ? w_t2 : w_t4;
    assign w_a   = r_s2_ctl.pass ? V'(r_s2_x) : (V'(r_s2_e) + V'(w_q));
    assign w_tl  = V'(r_s2_x) + V'(w_t2);

    assign w_last_step = r_s3_ctl.pass ? STEP_DETAIL :
                         (r_s3_ctl.tail ? STEP_TAIL : STEP_APPROX);
    assign w_emit      = r_s3_v && (!r_o_valid || i_ready);
    assign w_s3_load   = !r_s3_v || (w_emit && (r_step == w_last_step));

    always_comb begin
        case (r_step)
            STEP_DETAIL: n_step = STEP_APPROX;
            STEP_APPROX: n_step = STEP_TAIL;
            default:     n_step = STEP_DETAIL;
        endcase
    end

    always_comb begin
        case (r_step)
            STEP_DETAIL: begin
                if (r_s3_ctl.pass) begin
                    w_res  = r_s3_a;
                    w_band = BAND_APPROX;
                    w_idx  = '0;
                    w_done = 1'b1;
                end else begin
                    w_res  = V'(r_s3_d);
                    w_band = BAND_DETAIL;
                    w_idx  = r_s3_ctl.ci;
                    w_done = 1'b0;
                end
            end
            STEP_APPROX: begin
                w_res  = r_s3_a;
                w_band = BAND_APPROX;
                w_idx  = r_s3_ctl.ci;
                w_done = r_s3_ctl.done_a;
            end
            STEP_TAIL: begin
                w_res  = r_s3_tl;
                w_band = BAND_APPROX;
                w_idx  = r_s3_ctl.ci + IDX_BITS'(1);
                w_done = 1'b1;
            end
            default: begin
                w_res  = '0;
                w_band = BAND_APPROX;
                w_idx  = '0;
                w_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_step    <= STEP_DETAIL;
            r_pd      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_v <= i_q_valid;
            end
            if (w_s2_ready) begin
                r_s2_v <= r_s1_v;
            end
            if (w_s3_load) begin
                r_s3_v <= r_s2_v;
                r_step <= STEP_DETAIL;
                if (r_s2_v && r_s2_ctl.mid && !r_s2_ctl.pass) begin
                    r_pd <= r_s2_d;
                end
            end else if (w_emit) begin
                r_step <= n_step;
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready) begin
            r_s1_ctl <= i_ctl;
            r_s1_x   <= i_x;
            r_s1_e   <= i_e;
            r_s1_odd <= i_odd;
            r_s1_sum <= w_sum;
        end
        if (w_s2_ready) begin
            r_s2_ctl <= r_s1_ctl;
            r_s2_x   <= r_s1_x;
            r_s2_e   <= r_s1_e;
            r_s2_d   <= w_d;
        end
        if (w_s3_load) begin
            r_s3_ctl <= r_s2_ctl;
            r_s3_d   <= r_s2_d;
            r_s3_a   <= w_a;
            r_s3_tl  <= w_tl;
        end
        if (w_emit) begin
            r_o_coef <= w_res;
            r_o_band <= w_band;
            r_o_idx  <= w_idx;
            r_o_last <= w_done;
        end
    end

    assign o_valid = r_o_valid;
    assign o_coef  = COEF_BITS'(r_o_coef);
    assign o_band  = r_o_band;
    assign o_idx   = r_o_idx;
    assign o_last  = r_o_last;

    a_tail_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_v && r_step == STEP_TAIL) |-> (r_s3_ctl.tail && !r_s3_ctl.pass))
        else $error("tail step reached without a tail term");

    a_pass_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_v && r_s3_ctl.pass) |-> (r_step == STEP_DETAIL))
        else $error("pass-through job advanced past its only result");

    a_done_approx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> (r_o_band == BAND_APPROX))
        else $error("row end flagged on a detail term");

endmodule

// ===== hdl/forward_dwt53_lifting_1d.sv =====
// forward 5/3 integer lifting wavelet over one configurable-length row
// throughput: one sample per cycle while the job queue is not full; a sample emits
// 0 to 3 coefficients, one per cycle unless m_axis_tready stalls the output,
// and the 4-entry job queue absorbs the bursts at row ends
// reset: synchronous active-low, empties queue and pipeline, row length returns to 8
// depends on fwd53_pkg, fwd53_front, fwd53_queue, fwd53_back

module forward_dwt53_lifting_1d
    import fwd53_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_BITS-1:0]       i_cfg_wdata,   // row_length
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_BITS-1:0]        s_axis_tdata,  // sample
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,  // coefficient, band_index, zero pad
    output logic [0:0]                m_axis_tuser,  // band
    output logic                      m_axis_tlast   // row_done
);

    localparam int QW  = $bits(t_job_ctl) + 3 * SAMPLE_BITS;
    localparam int PAD = OUT_TDATA_BITS - COEF_BITS - IDX_BITS;

    logic                          w_push;
    t_job_ctl                      w_f_ctl;
    logic signed [SAMPLE_BITS-1:0] w_f_x;
    logic signed [SAMPLE_BITS-1:0] w_f_e;
    logic signed [SAMPLE_BITS-1:0] w_f_odd;
    logic                          w_q_full;
    logic                          w_q_valid;
    logic [QW-1:0]                 w_q_data;
    logic                          w_pop;
    t_job_ctl                      w_b_ctl;
    logic signed [SAMPLE_BITS-1:0] w_b_x;
    logic signed [SAMPLE_BITS-1:0] w_b_e;
    logic signed [SAMPLE_BITS-1:0] w_b_odd;
    logic [COEF_BITS-1:0]          w_coef;
    logic                          w_band;
    logic [IDX_BITS-1:0]           w_idx;

    fwd53_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_sample    (s_axis_tdata),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_ctl       (w_f_ctl),
        .o_x         (w_f_x),
        .o_e         (w_f_e),
        .o_odd       (w_f_odd)
    );

    fwd53_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_ctl, w_f_x, w_f_e, w_f_odd}),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_pop)
    );

    assign {w_b_ctl, w_b_x, w_b_e, w_b_odd} = w_q_data;

    fwd53_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_pop     (w_pop),
        .i_ctl     (w_b_ctl),
        .i_x       (w_b_x),
        .i_e       (w_b_e),
        .i_odd     (w_b_odd),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_coef    (w_coef),
        .o_band    (w_band),
        .o_idx     (w_idx),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {{PAD{1'b0}}, w_idx, w_coef};
    assign m_axis_tuser = w_band;

endmodule
